// File: hw/rtl/palette_nearest_neighbor_scaler_core_assert.svh
// Assertion macros for the scaler core.
// IMP checks a consequence in the same cycle, NXT checks it in the next cycle.
`ifndef PALETTE_NEAREST_NEIGHBOR_SCALER_CORE_ASSERT_SVH
`define PALETTE_NEAREST_NEIGHBOR_SCALER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PNNS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scaler core assertion failed");
`define PNNS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scaler core assertion failed");
`else
`define PNNS_ASSERT_IMP(name, clk, rst, ante, cons)
`define PNNS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/pnns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pnns_pkg;

   // field widths
   localparam int COORD_X_W = 9;
   localparam int COORD_Y_W = 8;
   localparam int SHADE_W   = 2;
   localparam int COLOR_W   = 16;
   localparam int MODE_W    = 2;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // scale modes; the unused code behaves as centered
   localparam logic [MODE_W-1:0] MODE_CENTER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FULL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIT    = 2'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // shade palette, RGB565
   localparam logic [COLOR_W-1:0] SHADE_COLORS [4] = '{16'hFFFF, 16'hAD55, 16'h52AA, 16'h0000};

   // what the back end has to do with a transaction
   typedef enum logic [2:0] {
      KIND_WRITE   = 3'd0,
      KIND_DIRECT  = 3'd1,
      KIND_FULL    = 3'd2,
      KIND_FIT     = 3'd3,
      KIND_OUTSIDE = 3'd4
   } pnns_kind_type;

   typedef struct packed {
      pnns_kind_type        kind;
      logic [COORD_X_W-1:0] coord_x;
      logic [COORD_Y_W-1:0] coord_y;
      logic [SHADE_W-1:0]   shade;
   } pnns_item_type;

endpackage

`default_nettype wire

// File: hw/rtl/pnns_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pnns_front import pnns_pkg::*; #(
   parameter int SRC_WIDTH  = 160,
   parameter int SRC_HEIGHT = 144,
   parameter int DST_WIDTH  = 320,
   parameter int DST_HEIGHT = 240
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [MODE_W-1:0]    csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [COORD_X_W-1:0] req_coord_x,
   input  logic [COORD_Y_W-1:0] req_coord_y,
   input  logic [SHADE_W-1:0]   req_shade,
   output logic                 push_valid,
   input  logic                 push_ready,
   output pnns_item_type        push_item
);

   localparam int XO_C   = (DST_WIDTH - SRC_WIDTH) / 2;
   localparam int YO_C   = (DST_HEIGHT - SRC_HEIGHT) / 2;
   localparam int W_FIT  = SRC_WIDTH * DST_HEIGHT / SRC_HEIGHT;
   localparam int XO_FIT = (DST_WIDTH - W_FIT) / 2;

   logic [MODE_W-1:0] scale_mode_ff;
   logic [MODE_W-1:0] scale_mode_in;
   int                x_i;
   int                y_i;
   logic              in_screen;
   logic              direct_ok;
   logic              fit_ok;
   logic              write_ok;
   pnns_kind_type     kind;

   // mode register
   always_comb begin
      scale_mode_in = scale_mode_ff;
      if (csr_wr_en) begin
         scale_mode_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_mode_ff <= MODE_CENTER;
      end else begin
         scale_mode_ff <= scale_mode_in;
      end
   end

   // range checks against the drawn area of each mode
   always_comb begin
      x_i       = int'(req_coord_x);
      y_i       = int'(req_coord_y);
      in_screen = (x_i < DST_WIDTH) && (y_i < DST_HEIGHT);
      direct_ok = (x_i >= XO_C) && (x_i < XO_C + SRC_WIDTH) &&
                  (y_i >= YO_C) && (y_i < YO_C + SRC_HEIGHT);
      fit_ok    = (x_i >= XO_FIT) && (x_i < XO_FIT + W_FIT);
      write_ok  = (x_i < SRC_WIDTH) && (y_i < SRC_HEIGHT);
   end

   // classify the transaction
   always_comb begin
      kind = KIND_OUTSIDE;
      if (req_operation == OP_WRITE) begin
         kind = KIND_WRITE;
      end else if (in_screen) begin
         case (scale_mode_ff)
            MODE_FULL: begin
               kind = KIND_FULL;
            end
            MODE_FIT: begin
               kind = fit_ok ? KIND_FIT : KIND_OUTSIDE;
            end
            default: begin
               kind = direct_ok ? KIND_DIRECT : KIND_OUTSIDE;
            end
         endcase
      end
   end

   // out-of-store writes are taken and dropped here
   assign req_ready         = push_ready;
   assign push_valid        = req_valid && ((req_operation == OP_READ) || write_ok);
   assign push_item.kind    = kind;
   assign push_item.coord_x = req_coord_x;
   assign push_item.coord_y = req_coord_y;
   assign push_item.shade   = req_shade;

endmodule

`default_nettype wire

// File: hw/rtl/pnns_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pnns_queue import pnns_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  pnns_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output pnns_item_type pop_item
);

   pnns_item_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;
   logic              push_fire;
   logic              pop_fire;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push_fire) - (QPTR_W + 1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pnns_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pnns_back import pnns_pkg::*; #(
   parameter int SRC_WIDTH  = 160,
   parameter int SRC_HEIGHT = 144,
   parameter int DST_WIDTH  = 320,
   parameter int DST_HEIGHT = 240
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  pnns_item_type      pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COLOR_W-1:0] rsp_color,
   output logic               rsp_inside_res
);

   localparam int XO_C   = (DST_WIDTH - SRC_WIDTH) / 2;
   localparam int YO_C   = (DST_HEIGHT - SRC_HEIGHT) / 2;
   localparam int W_FIT  = SRC_WIDTH * DST_HEIGHT / SRC_HEIGHT;
   localparam int XO_FIT = (DST_WIDTH - W_FIT) / 2;
   localparam int WW     = (W_FIT > 1) ? $clog2(W_FIT) : 1;
   localparam int SXW    = $clog2(SRC_WIDTH);
   localparam int SYW    = $clog2(SRC_HEIGHT);
   localparam int DEPTH  = SRC_WIDTH * SRC_HEIGHT;
   localparam int ADW    = $clog2(DEPTH);

   // reciprocals: q = (n * M) >> S is exact for every n the field can hold
   localparam int     FX_S  = COORD_X_W + $clog2(DST_WIDTH);
   localparam longint FX_M  = ((longint'(SRC_WIDTH) << FX_S) + longint'(DST_WIDTH) - 1)
                              / longint'(DST_WIDTH);
   localparam int     FX_MW = $clog2(FX_M + 1);
   localparam int     FX_PW = (COORD_X_W + FX_MW > FX_S + SXW) ? COORD_X_W + FX_MW
                                                               : FX_S + SXW;
   localparam logic [FX_PW-1:0] FX_MUL = FX_PW'(FX_M);

   localparam int     FY_S  = COORD_Y_W + $clog2(DST_HEIGHT);
   localparam longint FY_M  = ((longint'(SRC_HEIGHT) << FY_S) + longint'(DST_HEIGHT) - 1)
                              / longint'(DST_HEIGHT);
   localparam int     FY_MW = $clog2(FY_M + 1);
   localparam int     FY_PW = (COORD_Y_W + FY_MW > FY_S + SYW) ? COORD_Y_W + FY_MW
                                                               : FY_S + SYW;
   localparam logic [FY_PW-1:0] FY_MUL = FY_PW'(FY_M);

   localparam int     FT_S  = 2 * WW;
   localparam longint FT_M  = ((longint'(SRC_WIDTH) << FT_S) + longint'(W_FIT) - 1)
                              / longint'(W_FIT);
   localparam int     FT_MW = $clog2(FT_M + 1);
   localparam int     FT_PW = (WW + FT_MW > FT_S + SXW) ? WW + FT_MW : FT_S + SXW;
   localparam logic [FT_PW-1:0] FT_MUL = FT_PW'(FT_M);

   logic               adv;
   logic [WW-1:0]      rel;
   logic [FX_PW-1:0]   fx_prod;
   logic [FY_PW-1:0]   fy_prod;
   logic [FT_PW-1:0]   ft_prod;
   logic [SXW-1:0]     s1_sx_in;
   logic [SYW-1:0]     s1_sy_in;
   logic               s1_wr_in;
   logic               s1_inside_in;

   logic               s1_valid_ff;
   logic               s1_wr_ff;
   logic               s1_inside_ff;
   logic [SXW-1:0]     s1_sx_ff;
   logic [SYW-1:0]     s1_sy_ff;
   logic [SHADE_W-1:0] s1_shade_ff;

   logic               s2_valid_ff;
   logic               s2_wr_ff;
   logic               s2_inside_ff;
   logic [ADW-1:0]     s2_addr_ff;
   logic [ADW-1:0]     s2_addr_in;
   logic [SHADE_W-1:0] s2_shade_ff;

   logic               s3_valid_ff;
   logic               s3_inside_ff;
   logic [SHADE_W-1:0] s3_shade_ff;

   logic [SHADE_W-1:0] shade_store_ff [DEPTH];

   // the whole pipe moves unless a response is held
   assign adv       = !s3_valid_ff || rsp_ready;
   assign pop_ready = adv;

   // stage 1: map display coordinates to source coordinates
   always_comb begin
      rel     = WW'(int'(pop_item.coord_x) - XO_FIT);
      fx_prod = FX_PW'(pop_item.coord_x) * FX_MUL;
      fy_prod = FY_PW'(pop_item.coord_y) * FY_MUL;
      ft_prod = FT_PW'(rel) * FT_MUL;
      s1_wr_in     = (pop_item.kind == KIND_WRITE);
      s1_inside_in = 1'b0;
      s1_sx_in     = '0;
      s1_sy_in     = '0;
      case (pop_item.kind)
         KIND_WRITE: begin
            s1_sx_in = SXW'(pop_item.coord_x);
            s1_sy_in = SYW'(pop_item.coord_y);
         end
         KIND_DIRECT: begin
            s1_inside_in = 1'b1;
            s1_sx_in     = SXW'(int'(pop_item.coord_x) - XO_C);
            s1_sy_in     = SYW'(int'(pop_item.coord_y) - YO_C);
         end
         KIND_FULL: begin
            s1_inside_in = 1'b1;
            s1_sx_in     = fx_prod[FX_S +: SXW];
            s1_sy_in     = fy_prod[FY_S +: SYW];
         end
         KIND_FIT: begin
            s1_inside_in = 1'b1;
            s1_sx_in     = ft_prod[FT_S +: SXW];
            s1_sy_in     = fy_prod[FY_S +: SYW];
         end
         default: begin
            s1_inside_in = 1'b0;
         end
      endcase
   end

   // stage 2: linear store address
   assign s2_addr_in = ADW'(s1_sy_ff) * ADW'(SRC_WIDTH) + ADW'(s1_sx_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= pop_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && !s2_wr_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_wr_ff     <= s1_wr_in;
         s1_inside_ff <= s1_inside_in;
         s1_sx_ff     <= s1_sx_in;
         s1_sy_ff     <= s1_sy_in;
         s1_shade_ff  <= pop_item.shade;
         s2_wr_ff     <= s1_wr_ff;
         s2_inside_ff <= s1_inside_ff;
         s2_addr_ff   <= s2_addr_in;
         s2_shade_ff  <= s1_shade_ff;
         s3_inside_ff <= s2_inside_ff;
      end
   end

   // stage 3: shade store, one access per cycle while the pipe advances
   always_ff @(posedge clock) begin
      if (adv) begin
         if (s2_valid_ff && s2_wr_ff) begin
            shade_store_ff[s2_addr_ff] <= s2_shade_ff;
         end
         s3_shade_ff <= shade_store_ff[s2_addr_ff];
      end
   end

   // palette lookup on the held response
   assign rsp_valid      = s3_valid_ff;
   assign rsp_inside_res = s3_inside_ff;
   assign rsp_color      = s3_inside_ff ? SHADE_COLORS[s3_shade_ff] : '0;

endmodule

`default_nettype wire

// File: hw/rtl/palette_nearest_neighbor_scaler_core.sv
// Channel  Dir  Handshake                Payload
// req      in   req_valid / req_ready    req_operation, req_coord_x, req_coord_y, req_shade
// rsp      out  rsp_valid / rsp_ready    rsp_color, rsp_inside_res
// csr      in   csr_wr_en                csr_wr_data (scale mode)
//
// One transaction per clock sustained while no response is held, set by the single-port shade store.
// A read is answered through the queue and stages 1, 2 and 3 of the back pipeline; writes give no response.
// Reset is synchronous: clears queue, pipeline valids and the scale mode;
// the shade store is not cleared.
// A response held with rsp_ready low freezes the back pipeline; the 4-entry queue then takes
// up to 4 more transactions before req_ready drops.
`timescale 1ns / 1ps
`default_nettype none

`include "palette_nearest_neighbor_scaler_core_assert.svh"

module palette_nearest_neighbor_scaler_core import pnns_pkg::*; #(
   parameter int SRC_WIDTH  = 160,
   parameter int SRC_HEIGHT = 144,
   parameter int DST_WIDTH  = 320,
   parameter int DST_HEIGHT = 240
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [MODE_W-1:0]    csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [COORD_X_W-1:0] req_coord_x,
   input  logic [COORD_Y_W-1:0] req_coord_y,
   input  logic [SHADE_W-1:0]   req_shade,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COLOR_W-1:0]   rsp_color,
   output logic                 rsp_inside_res
);

   logic          q_push_valid;
   logic          q_push_ready;
   pnns_item_type q_push_item;
   logic          q_pop_valid;
   logic          q_pop_ready;
   pnns_item_type q_pop_item;

   // front: mode register and classification
   pnns_front #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT),
      .DST_WIDTH  (DST_WIDTH),
      .DST_HEIGHT (DST_HEIGHT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_coord_x   (req_coord_x),
      .req_coord_y   (req_coord_y),
      .req_shade     (req_shade),
      .push_valid    (q_push_valid),
      .push_ready    (q_push_ready),
      .push_item     (q_push_item)
   );

   // decoupling queue
   pnns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item)
   );

   // back: mapping, shade store, palette
   pnns_back #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT),
      .DST_WIDTH  (DST_WIDTH),
      .DST_HEIGHT (DST_HEIGHT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (q_pop_valid),
      .pop_ready      (q_pop_ready),
      .pop_item       (q_pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_color      (rsp_color),
      .rsp_inside_res (rsp_inside_res)
   );

   // checks
   `PNNS_ASSERT_IMP(a_outside_black, clock, reset, rsp_valid && !rsp_inside_res, rsp_color == '0)
   `PNNS_ASSERT_IMP(a_stall_no_pop, clock, reset, rsp_valid && !rsp_ready, !(q_pop_valid && q_pop_ready))
   `PNNS_ASSERT_NXT(a_push_visible, clock, reset, q_push_valid && q_push_ready, q_pop_valid)

endmodule

`default_nettype wire

// File: tb/tb_palette_nearest_neighbor_scaler_core.sv
`timescale 1ns / 1ps

module tb_palette_nearest_neighbor_scaler_core;
   import pnns_pkg::*;

   // geometry of the default configuration
   localparam int SRC_W       = 160;
   localparam int SRC_H       = 144;
   localparam int DST_W       = 320;
   localparam int DST_H       = 240;
   localparam int STORE_DEPTH = SRC_W * SRC_H;

   // the one mode code without a name in the package
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // quiet cycles before a mode change and at the end, watchdog limit
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 155;
   localparam int PHASE_COUNT  = 8;

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               in_area;
   } pixel_result_type;

   // mirror of the frame store and mode, plus the expected pixels in order
   class shade_frame_mirror;
      bit [1:0]          shades  [STORE_DEPTH];
      bit                painted [STORE_DEPTH];
      logic [MODE_W-1:0] mode;
      pixel_result_type  pending_pixels [$];
      int                mismatches;

      function new();
         mode       = MODE_CENTER;
         mismatches = 0;
         foreach (painted[i]) painted[i] = 1'b0;
      endfunction

      function logic [COLOR_W-1:0] tone_rgb565(bit [1:0] tone);
         case (tone)
            2'd0:    return 16'hFFFF;
            2'd1:    return 16'hAD55;
            2'd2:    return 16'h52AA;
            default: return 16'h0000;
         endcase
      endfunction

      // display pixel to source pixel; 0 when outside the drawn area
      function bit locate_source(int x, int y, output int sx, output int sy);
         int span;
         int xo;
         int rel;
         sx = 0;
         sy = 0;
         if (x >= DST_W || y >= DST_H) return 1'b0;
         case (mode)
            MODE_FULL: begin
               sx = x * SRC_W / DST_W;
               sy = y * SRC_H / DST_H;
            end
            MODE_FIT: begin
               span = SRC_W * DST_H / SRC_H;
               xo   = (DST_W - span) / 2;
               rel  = x - xo;
               if (rel < 0 || rel >= span) return 1'b0;
               sx = rel * SRC_W / span;
               sy = y * SRC_H / DST_H;
            end
            default: begin
               sx = x - (DST_W - SRC_W) / 2;
               sy = y - (DST_H - SRC_H) / 2;
            end
         endcase
         return (sx >= 0 && sx < SRC_W && sy >= 0 && sy < SRC_H);
      endfunction

      // one accepted request transaction
      function void accept_request(logic op, logic [COORD_X_W-1:0] cx,
                                   logic [COORD_Y_W-1:0] cy, logic [SHADE_W-1:0] tone);
         int               x;
         int               y;
         int               sx;
         int               sy;
         pixel_result_type px;
         x = int'(cx);
         y = int'(cy);
         if (op == OP_WRITE) begin
            // writes off the store are dropped
            if (x < SRC_W && y < SRC_H) begin
               shades[y * SRC_W + x]  = tone;
               painted[y * SRC_W + x] = 1'b1;
            end
         end else begin
            if (locate_source(x, y, sx, sy)) begin
               px.color   = tone_rgb565(shades[sy * SRC_W + sx]);
               px.in_area = 1'b1;
            end else begin
               px.color   = '0;
               px.in_area = 1'b0;
            end
            pending_pixels.push_back(px);
         end
      endfunction

      // one accepted response transaction against the oldest expected pixel
      function void compare_pixel(logic [COLOR_W-1:0] color, logic in_area);
         pixel_result_type px;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected response, color %h inside_res %b", $time, color,
                     in_area);
            mismatches++;
            return;
         end
         px = pending_pixels.pop_front();
         if (color !== px.color) begin
            $display("%0t: color expected %h got %h", $time, px.color, color);
            mismatches++;
         end
         if (in_area !== px.in_area) begin
            $display("%0t: inside_res expected %b got %b", $time, px.in_area, in_area);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 csr_wr_en      = 1'b0;
   logic [MODE_W-1:0]    csr_wr_data    = '0;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_operation  = OP_WRITE;
   logic [COORD_X_W-1:0] req_coord_x    = '0;
   logic [COORD_Y_W-1:0] req_coord_y    = '0;
   logic [SHADE_W-1:0]   req_shade      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [COLOR_W-1:0]   rsp_color;
   logic                 rsp_inside_res;

   shade_frame_mirror mirror;
   bit                steady = 1'b0;
   int                items_sent = 0;
   int                idle_cycles = 0;

   palette_nearest_neighbor_scaler_core u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_shade      (req_shade),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_color      (rsp_color),
      .rsp_inside_res (rsp_inside_res)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int idle_draw();
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   // drive one request transaction and hold it until accepted
   task automatic send_item(logic op, int x, int y, int tone);
      int gap;
      // stretches without idling on either side
      if (items_sent % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_coord_x   <= COORD_X_W'(x);
      req_coord_y   <= COORD_Y_W'(y);
      req_shade     <= SHADE_W'(tone);
      do @(posedge clock); while (!req_ready);
      mirror.accept_request(op, COORD_X_W'(x), COORD_Y_W'(y), SHADE_W'(tone));
      items_sent++;
   endtask

   // a read whose source pixel was never written gets a write first
   task automatic issue_read(int x, int y);
      int sx;
      int sy;
      if (mirror.locate_source(x, y, sx, sy) && !mirror.painted[sy * SRC_W + sx])
         send_item(OP_WRITE, sx, sy, $urandom_range(0, 3));
      send_item(OP_READ, x, y, $urandom_range(0, 3));
   endtask

   // mode change only with the block drained
   task automatic set_mode(logic [MODE_W-1:0] m);
      req_valid <= 1'b0;
      while (mirror.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror.mode = m;
   endtask

   // coordinates near the borders of the three mappings
   function automatic int edge_x();
      case ($urandom_range(0, 20))
         0:  return 0;
         1:  return 1;
         2:  return 26;
         3:  return 27;
         4:  return 28;
         5:  return 79;
         6:  return 80;
         7:  return 81;
         8:  return 158;
         9:  return 159;
         10: return 160;
         11: return 161;
         12: return 239;
         13: return 240;
         14: return 291;
         15: return 292;
         16: return 293;
         17: return 318;
         18: return 319;
         19: return 320;
         default: return 511;
      endcase
   endfunction

   function automatic int edge_y();
      case ($urandom_range(0, 10))
         0:  return 0;
         1:  return 1;
         2:  return 47;
         3:  return 48;
         4:  return 49;
         5:  return 191;
         6:  return 192;
         7:  return 238;
         8:  return 239;
         9:  return 240;
         default: return 255;
      endcase
   endfunction

   task automatic random_transaction();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         send_item(OP_WRITE, $urandom_range(0, SRC_W - 1), $urandom_range(0, SRC_H - 1),
                   $urandom_range(0, 3));
      else if (pick < 38)
         send_item(OP_WRITE, $urandom_range(0, 511), $urandom_range(0, 255),
                   $urandom_range(0, 3));
      else if (pick < 58)
         issue_read(edge_x(), edge_y());
      else if (pick < 92)
         issue_read($urandom_range(0, DST_W - 1), $urandom_range(0, DST_H - 1));
      else
         issue_read($urandom_range(0, 511), $urandom_range(0, 255));
   endtask

   // response side: random stall before each response transaction
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.compare_pixel(rsp_color, rsp_inside_res);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("palette_nearest_neighbor_scaler_core test failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [MODE_W-1:0] phase_mode [PHASE_COUNT];
      mirror = new();
      phase_mode = '{MODE_FULL, MODE_FIT, MODE_UNUSED, MODE_CENTER,
                     MODE_FIT, MODE_FULL, MODE_CENTER, MODE_UNUSED};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: store corners, off-store writes, centered mode after reset
      send_item(OP_WRITE, 0, 0, 0);
      send_item(OP_WRITE, 159, 0, 1);
      send_item(OP_WRITE, 0, 143, 2);
      send_item(OP_WRITE, 159, 143, 3);
      send_item(OP_WRITE, 0, 1, 1);
      send_item(OP_WRITE, 160, 0, 3);
      send_item(OP_WRITE, 511, 255, 2);
      send_item(OP_WRITE, 0, 144, 3);
      send_item(OP_READ, 80, 48, 0);
      send_item(OP_READ, 239, 48, 3);
      send_item(OP_READ, 80, 191, 1);
      send_item(OP_READ, 239, 191, 2);
      send_item(OP_READ, 80, 49, 0);
      send_item(OP_READ, 79, 48, 0);
      send_item(OP_READ, 240, 191, 0);
      send_item(OP_READ, 80, 47, 0);
      send_item(OP_READ, 80, 192, 0);
      send_item(OP_READ, 319, 239, 0);
      send_item(OP_READ, 511, 255, 3);
      send_item(OP_READ, 0, 0, 2);

      // random phases over every mode code
      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_mode(phase_mode[p]);
         while (items_sent < 20 + (p + 1) * PHASE_ITEMS) random_transaction();
      end

      // drain and report
      req_valid <= 1'b0;
      while (mirror.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0)
         $display("palette_nearest_neighbor_scaler_core test passed");
      else
         $display("palette_nearest_neighbor_scaler_core test failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pnns_pkg.sv
hw/rtl/pnns_front.sv
hw/rtl/pnns_queue.sv
hw/rtl/pnns_back.sv
hw/rtl/palette_nearest_neighbor_scaler_core.sv
tb/tb_palette_nearest_neighbor_scaler_core.sv
